[hw/rtl/uart_key_frame_receiver_defines.svh]
// Assertion macros shared by the key frame receiver RTL.
`ifndef UART_KEY_FRAME_RECEIVER_DEFINES_SVH
`define UART_KEY_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF

// a holds in a cycle -> c holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("ukfr assertion failed");

// a holds in a cycle -> c holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("ukfr assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)

`endif

`endif

[hw/rtl/ukfr_pkg.sv]
// Types, codes and helper functions of the key frame receiver.
`default_nettype none

package ukfr_pkg;

    localparam logic [2:0] KIND_RX    = 3'd0;
    localparam logic [2:0] KIND_TICK  = 3'd1;
    localparam logic [2:0] KIND_POLL  = 3'd2;
    localparam logic [2:0] KIND_CLEAR = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [2:0] CFG_START_BYTE   = 3'd0;
    localparam logic [2:0] CFG_END_BYTE     = 3'd1;
    localparam logic [2:0] CFG_ASCII_MODE   = 3'd2;
    localparam logic [2:0] CFG_COMMAND_CODE = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT      = 3'd4;

    localparam logic [47:0] PAT_REQUEST   = "MS=02,";
    localparam logic [47:0] PAT_CONNECTED = "RS=02,";
    localparam logic [2:0]  MATCH_DONE    = 3'd6;

    localparam logic [7:0] KEY_LIMIT = 8'h80;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] rx_byte;
        logic [3:0] addr_select;
    } t_item;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic        ascii_mode;
        logic [7:0]  command_code;
        logic [15:0] connect_timeout;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        start_byte:      8'd2,
        end_byte:        8'd3,
        ascii_mode:      1'b0,
        command_code:    8'd0,
        connect_timeout: 16'd600
    };

    typedef struct packed {
        logic       key_ready;
        logic [7:0] key_value;
        logic [7:0] extra_key;
        logic [7:0] ctrl_type;
    } t_key_status;

    typedef struct packed {
        logic       should_connect;
        logic       connected;
        logic       connect_request;
        logic [3:0] addr_count;
        logic [7:0] addr_byte;
    } t_link_status;

    // hex character to nibble, anything else reads as zero
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

    // one step of the pattern matcher; a step at or past the end falls back to 0
    function automatic logic [2:0] match_next(input logic [47:0] pat,
                                              input logic [2:0]  step,
                                              input logic [7:0]  b);
        logic [7:0] ch;
        logic       in_range;
        in_range = 1'b1;
        case (step)
            3'd0: ch = pat[47:40];
            3'd1: ch = pat[39:32];
            3'd2: ch = pat[31:24];
            3'd3: ch = pat[23:16];
            3'd4: ch = pat[15:8];
            3'd5: ch = pat[7:0];
            default: begin
                ch       = 8'h00;
                in_range = 1'b0;
            end
        endcase
        return (in_range && ch == b) ? step + 3'd1 : 3'd0;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ukfr_frame.sv]
// Frame collector and key decoder of the key frame receiver.
`default_nettype none

module ukfr_frame #(
    parameter int FRAME_DEPTH = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_fire,
    input  ukfr_pkg::t_item       i_item,
    input  ukfr_pkg::t_cfg        i_cfg,
    output ukfr_pkg::t_key_status o_status
);

    localparam int IW   = $clog2(FRAME_DEPTH);
    localparam int KEPT = 4;    // only the first four frame bytes are ever decoded

    logic [7:0]    r_store [KEPT];
    logic [IW-1:0] r_index;
    logic          r_key_ready;
    logic [7:0]    r_key;
    logic [7:0]    r_extra;
    logic [7:0]    r_ctrl;

    logic [7:0]    n_store [KEPT];
    logic [IW-1:0] n_index;
    logic          n_key_ready;
    logic [7:0]    n_key;
    logic [7:0]    n_extra;
    logic [7:0]    n_ctrl;

    logic [7:0]    cmd;

    always_comb begin
        n_store     = r_store;
        n_index     = r_index;
        n_key_ready = r_key_ready;
        n_key       = r_key;
        n_extra     = r_extra;
        n_ctrl      = r_ctrl;
        cmd = {ukfr_pkg::hex_val(r_store[0]), ukfr_pkg::hex_val(r_store[1])};
        case (i_item.kind)
            ukfr_pkg::KIND_RX: begin
                if (i_item.rx_byte == i_cfg.start_byte) begin
                    n_index = '0;
                end else if (i_item.rx_byte == i_cfg.end_byte) begin
                    if (!i_cfg.ascii_mode) begin
                        n_ctrl  = r_store[0];
                        n_key   = r_store[1];
                        n_extra = r_store[2];
                        if (r_store[1] < ukfr_pkg::KEY_LIMIT) begin
                            n_key_ready = 1'b1;
                        end
                    end else if (cmd == i_cfg.command_code) begin
                        n_key = {ukfr_pkg::hex_val(r_store[2]),
                                 ukfr_pkg::hex_val(r_store[3])};
                        n_key_ready = 1'b1;
                    end
                end else begin
                    if (9'(r_index) < 9'(KEPT)) begin
                        n_store[r_index[1:0]] = i_item.rx_byte;
                    end
                    n_index = (r_index == IW'(FRAME_DEPTH - 1)) ? '0 : r_index + 1'b1;
                end
            end
            ukfr_pkg::KIND_CLEAR: begin
                n_key_ready = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEPT; i++) begin
                r_store[i] <= 8'h00;
            end
            r_index     <= '0;
            r_key_ready <= 1'b0;
            r_key       <= 8'h00;
            r_extra     <= 8'h00;
            r_ctrl      <= 8'h00;
        end else if (i_fire) begin
            r_store     <= n_store;
            r_index     <= n_index;
            r_key_ready <= n_key_ready;
            r_key       <= n_key;
            r_extra     <= n_extra;
            r_ctrl      <= n_ctrl;
        end
    end

    assign o_status.key_ready = n_key_ready;
    assign o_status.key_value = n_key;
    assign o_status.extra_key = n_extra;
    assign o_status.ctrl_type = n_ctrl;

endmodule

`default_nettype wire

[hw/rtl/ukfr_link.sv]
// Link matcher, address capture and connect timeout of the key frame receiver.
`default_nettype none

`include "uart_key_frame_receiver_defines.svh"

module ukfr_link #(
    parameter int ADDR_BYTES = 12
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_fire,
    input  ukfr_pkg::t_item        i_item,
    input  ukfr_pkg::t_cfg         i_cfg,
    output ukfr_pkg::t_link_status o_status
);

    localparam int CW = $clog2(ADDR_BYTES + 1);
    localparam int AW = (ADDR_BYTES > 1) ? $clog2(ADDR_BYTES) : 1;

    logic [7:0]    r_store [ADDR_BYTES];
    logic [CW-1:0] r_count;
    logic          r_pending;
    logic          r_connected;
    logic [2:0]    r_step;
    logic [15:0]   r_tick;

    logic [7:0]    n_store [ADDR_BYTES];
    logic [CW-1:0] n_count;
    logic          n_pending;
    logic          n_connected;
    logic [2:0]    n_step;
    logic [15:0]   n_tick;

    logic          request;
    logic [7:0]    abyte;
    logic [4:0]    count_ext;

    always_comb begin
        n_store     = r_store;
        n_count     = r_count;
        n_pending   = r_pending;
        n_connected = r_connected;
        n_step      = r_step;
        n_tick      = r_tick;
        request     = 1'b0;
        abyte       = 8'h00;
        case (i_item.kind)
            ukfr_pkg::KIND_RX: begin
                if (r_pending && 5'(r_count) < 5'(ADDR_BYTES)) begin
                    n_store[r_count[AW-1:0]] = i_item.rx_byte;
                    n_count = r_count + 1'b1;
                end
                // both matchers share one step counter
                if (!r_pending) begin
                    n_step = ukfr_pkg::match_next(ukfr_pkg::PAT_REQUEST, n_step,
                                                  i_item.rx_byte);
                    if (n_step == ukfr_pkg::MATCH_DONE) begin
                        n_pending = 1'b1;
                        n_tick    = 16'h0000;
                        n_count   = '0;
                        n_step    = 3'd0;
                    end
                end
                if (n_pending) begin
                    n_step = ukfr_pkg::match_next(ukfr_pkg::PAT_CONNECTED, n_step,
                                                  i_item.rx_byte);
                    if (n_step == ukfr_pkg::MATCH_DONE) begin
                        n_connected = 1'b1;
                    end
                end
            end
            ukfr_pkg::KIND_TICK: begin
                if (r_tick != 16'hFFFF) begin
                    n_tick = r_tick + 16'd1;
                end
            end
            ukfr_pkg::KIND_POLL: begin
                if (r_pending && !r_connected && r_tick >= i_cfg.connect_timeout) begin
                    n_pending = 1'b0;
                    request   = 1'b1;
                end
            end
            ukfr_pkg::KIND_READ: begin
                if (5'(i_item.addr_select) < 5'(ADDR_BYTES)) begin
                    abyte = r_store[i_item.addr_select[AW-1:0]];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ADDR_BYTES; i++) begin
                r_store[i] <= 8'h00;
            end
            r_count     <= '0;
            r_pending   <= 1'b0;
            r_connected <= 1'b0;
            r_step      <= 3'd0;
            r_tick      <= 16'h0000;
        end else if (i_fire) begin
            r_store     <= n_store;
            r_count     <= n_count;
            r_pending   <= n_pending;
            r_connected <= n_connected;
            r_step      <= n_step;
            r_tick      <= n_tick;
        end
    end

    assign count_ext = 5'(n_count);

    assign o_status.should_connect  = n_pending;
    assign o_status.connected       = n_connected;
    assign o_status.connect_request = request;
    assign o_status.addr_count      = count_ext[3:0];
    assign o_status.addr_byte       = abyte;

    // a poll only fires while unconnected, so connected keeps the request pending
    `ASSERT_IMPLIES(a_conn_pending, i_clk, i_rst_n, r_connected, r_pending)
    `ASSERT_IMPLIES(a_count_max, i_clk, i_rst_n, 1'b1, 5'(r_count) <= 5'(ADDR_BYTES))
    `ASSERT_NEXT(a_poll_drops, i_clk, i_rst_n, i_fire && request, !r_pending)

endmodule

`default_nettype wire

[hw/rtl/uart_key_frame_receiver.sv]
// Top level of the UART key frame receiver: input stage, result stage, config registers.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one item: a received byte, a timer
//   tick, a connect poll, a key-ready clear or an address byte read (i_kind).
//   Each item produces exactly one result on the output channel (o_valid /
//   i_stall) with the key status, link status and the selected address byte.
//   Configuration (start/end byte, ASCII mode, command code, connect timeout) is
//   written on the i_cfg_* channel, which is always ready; write it only idle.
//   An item taken is held in the input register, then its result is written to
//   the result register and can be taken from there (input register, then result
//   register). Throughput: one item per cycle while the receiver does not hold
//   i_stall; the update of all state is a single pass of compare logic between the two registers.
//   When the receiver holds i_stall, the result register holds, the input
//   register still takes one more item, then o_stall rises until a slot frees.
//   Reset (i_rst_n low, synchronous) clears both stages, all key and link state
//   and the stored frame and address bytes, and restores the register defaults.
`default_nettype none

`include "uart_key_frame_receiver_defines.svh"

module uart_key_frame_receiver #(
    parameter int FRAME_DEPTH = 16,
    parameter int ADDR_BYTES  = 12
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,

    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [2:0]  i_kind,
    input  wire  [7:0]  i_rx_byte,
    input  wire  [3:0]  i_addr_select,

    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_key_ready,
    output logic [7:0]  o_key_value,
    output logic [7:0]  o_extra_key,
    output logic [7:0]  o_ctrl_type,
    output logic        o_should_connect,
    output logic        o_connected,
    output logic        o_connect_request,
    output logic [3:0]  o_addr_count,
    output logic [7:0]  o_addr_byte
);

    ukfr_pkg::t_cfg         r_cfg;
    logic                   r_in_valid;
    ukfr_pkg::t_item        r_in_item;
    logic                   r_out_valid;
    ukfr_pkg::t_key_status  r_out_key;
    ukfr_pkg::t_link_status r_out_link;

    ukfr_pkg::t_key_status  key_next;
    ukfr_pkg::t_link_status link_next;
    logic                   advance;
    logic                   accept;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ukfr_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ukfr_pkg::CFG_START_BYTE:   r_cfg.start_byte      <= i_cfg_data[7:0];
                ukfr_pkg::CFG_END_BYTE:     r_cfg.end_byte        <= i_cfg_data[7:0];
                ukfr_pkg::CFG_ASCII_MODE:   r_cfg.ascii_mode      <= i_cfg_data[0];
                ukfr_pkg::CFG_COMMAND_CODE: r_cfg.command_code    <= i_cfg_data[7:0];
                ukfr_pkg::CFG_TIMEOUT:      r_cfg.connect_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item.kind        <= i_kind;
            r_in_item.rx_byte     <= i_rx_byte;
            r_in_item.addr_select <= i_addr_select;
        end
    end

    ukfr_frame #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_status (key_next)
    );

    ukfr_link #(
        .ADDR_BYTES (ADDR_BYTES)
    ) u_link (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_status (link_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_key  <= key_next;
            r_out_link <= link_next;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_key_ready       = r_out_key.key_ready;
    assign o_key_value       = r_out_key.key_value;
    assign o_extra_key       = r_out_key.extra_key;
    assign o_ctrl_type       = r_out_key.ctrl_type;
    assign o_should_connect  = r_out_link.should_connect;
    assign o_connected       = r_out_link.connected;
    assign o_connect_request = r_out_link.connect_request;
    assign o_addr_count      = r_out_link.addr_count;
    assign o_addr_byte       = r_out_link.addr_byte;

    // a reconnect pulse always comes with the pending request dropped
    `ASSERT_IMPLIES(a_req_drops, i_clk, i_rst_n, r_out_valid && r_out_link.connect_request, !r_out_link.should_connect)
    // a full input stage behind a stalled result must push back
    `ASSERT_IMPLIES(a_backpressure, i_clk, i_rst_n, r_in_valid && r_out_valid && i_stall, o_stall)

endmodule

`default_nettype wire
